FILE: rtl/mrn_pkg.sv
// Shared types and constants for the maze robot navigation controller.
// No dependencies; every other file but mrn_ram imports this package.
package mrn_pkg;

	localparam int GRID_ROWS_DEF = 16;
	localparam int GRID_COLS_DEF = 16;

	// Configuration register indexes
	localparam logic REG_STEPS_CELL = 1'b0;
	localparam logic REG_STEPS_TURN = 1'b1;

	// Motor commands
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_STOP    = 3'd1;
	localparam logic [2:0] CMD_FORWARD = 3'd2;
	localparam logic [2:0] CMD_RIGHT   = 3'd3;
	localparam logic [2:0] CMD_LEFT    = 3'd4;

	// Mode codes as seen on the result
	localparam logic [1:0] MODE_ADVANCE = 2'd0;
	localparam logic [1:0] MODE_BRAKE   = 2'd1;
	localparam logic [1:0] MODE_HALT    = 2'd2;
	localparam logic [1:0] MODE_TURN    = 2'd3;

	// Headings
	localparam logic [1:0] HD_NORTH = 2'd0;
	localparam logic [1:0] HD_EAST  = 2'd1;
	localparam logic [1:0] HD_SOUTH = 2'd2;
	localparam logic [1:0] HD_WEST  = 2'd3;

	typedef enum logic [3:0] {
		ST_ADVANCE = 4'b0001,
		ST_BRAKE   = 4'b0010,
		ST_HALT    = 4'b0100,
		ST_TURN    = 4'b1000
	} mode_e;

	typedef struct packed {
		logic       wall_front;
		logic       wall_right;
		logic       wall_left;
		logic       is_stopped;
		logic [7:0] wheel_count;
	} in_t;

	typedef struct packed {
		logic [2:0] motor_cmd;
		logic       clear_wheel_count;
		logic [1:0] mode;
		logic [3:0] pos_row;
		logic [3:0] pos_col;
		logic [1:0] heading;
		logic [3:0] goal_row;
		logic [3:0] goal_col;
		logic [1:0] goal_heading;
		logic       move_blocked;
	} out_t;

	// Grid cell with an in-grid flag
	typedef struct packed {
		logic       ok;
		logic [3:0] row;
		logic [3:0] col;
	} cell_t;

	// Controller to visited-map unit
	typedef struct packed {
		logic       we;
		logic [3:0] wr_row;
		logic [3:0] wr_col;
		cell_t      rd_a;
		cell_t      rd_b;
	} map_req_t;

	// Visited-map unit to controller and top
	typedef struct packed {
		logic busy;
		logic vis_a;
		logic vis_b;
	} map_stat_t;

endpackage

FILE: rtl/mrn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read during write returns the old contents.
module mrn_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mrn_visit.sv
// Visited-cell map: two RAM copies (one per read port), clearing sweep after
// reset and write-to-read forwarding. Depends on mrn_pkg and mrn_ram.
module mrn_visit
	import mrn_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  map_req_t  req,
	output map_stat_t stat
);

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(DEPTH);

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          wen;
	logic [AW-1:0] waddr;
	logic          wdata;
	logic [AW-1:0] raddr_a, raddr_b;
	logic          q_a, q_b;
	logic          fwd_a_q, fwd_b_q, fwd_d_q;
	logic          ok_a_q, ok_b_q;

	function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
		return AW'(int'(r) * GRID_COLS + int'(c));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		raddr_a = cell_addr(req.rd_a.row, req.rd_a.col);
		raddr_b = cell_addr(req.rd_b.row, req.rd_b.col);
		if (clearing_q) begin
			wen   = 1'b1;
			waddr = clr_addr_q;
			wdata = 1'b0;
		end else begin
			wen   = req.we;
			waddr = cell_addr(req.wr_row, req.wr_col);
			wdata = 1'b1;
		end
	end

	mrn_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (q_a)
	);

	mrn_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (q_b)
	);

	// same-edge write wins over the RAM's old data
	always_ff @(posedge clk) begin
		fwd_a_q <= wen && (waddr == raddr_a);
		fwd_b_q <= wen && (waddr == raddr_b);
		fwd_d_q <= wdata;
		ok_a_q  <= req.rd_a.ok;
		ok_b_q  <= req.rd_b.ok;
	end

	assign stat.busy  = clearing_q;
	assign stat.vis_a = ok_a_q && (fwd_a_q ? fwd_d_q : q_a);
	assign stat.vis_b = ok_b_q && (fwd_b_q ? fwd_d_q : q_b);

endmodule

FILE: rtl/mrn_ctrl.sv
// Navigation controller: mode machine, pose and goal registers, per-tick
// update and visited-map lookups for the next tick. Depends on mrn_pkg.
module mrn_ctrl
	import mrn_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_t       item,
	input  logic [7:0] steps_cell,
	input  logic [7:0] steps_turn,
	input  map_stat_t stat,
	output out_t      result,
	output map_req_t  req
);

	mode_e      mode_q, n_mode;
	logic [3:0] row_q, col_q, trow_q, tcol_q;
	logic [1:0] hd_q, thd_q, phd_q;
	logic [3:0] n_row, n_col, n_trow, n_tcol;
	logic [1:0] n_hd, n_thd, n_phd, diff, rd_hd;
	logic [2:0] cmd;
	logic       clr, blk, we, at_goal, moved, turned, next_vis;
	cell_t      ahead, tgt_next, rd_a, rd_b;

	function automatic cell_t neighbor(input logic [3:0] r, input logic [3:0] c,
			input logic [1:0] h);
		cell_t n;
		n = '{ok: 1'b1, row: r, col: c};
		unique case (h)
			HD_NORTH: begin
				if ((5'(r) + 5'd1) >= 5'(GRID_ROWS)) n.ok = 1'b0;
				else n.row = r + 4'd1;
			end
			HD_EAST: begin
				if ((5'(c) + 5'd1) >= 5'(GRID_COLS)) n.ok = 1'b0;
				else n.col = c + 4'd1;
			end
			HD_SOUTH: begin
				if (r == 4'd0) n.ok = 1'b0;
				else n.row = r - 4'd1;
			end
			HD_WEST: begin
				if (c == 4'd0) n.ok = 1'b0;
				else n.col = c - 4'd1;
			end
		endcase
		return n;
	endfunction

	function automatic logic [1:0] mode_code(input mode_e m);
		logic [1:0] code;
		unique case (m)
			ST_ADVANCE: code = MODE_ADVANCE;
			ST_BRAKE:   code = MODE_BRAKE;
			ST_HALT:    code = MODE_HALT;
			ST_TURN:    code = MODE_TURN;
			default:    code = MODE_ADVANCE;
		endcase
		return code;
	endfunction

	always_comb begin
		n_mode   = mode_q;
		n_row    = row_q;
		n_col    = col_q;
		n_hd     = hd_q;
		n_trow   = trow_q;
		n_tcol   = tcol_q;
		n_thd    = thd_q;
		n_phd    = phd_q;
		cmd      = CMD_NONE;
		clr      = 1'b0;
		blk      = 1'b0;
		we       = 1'b0;
		moved    = 1'b0;
		turned   = 1'b0;
		next_vis = 1'b0;
		at_goal  = (row_q == trow_q) && (col_q == tcol_q);
		diff     = thd_q - hd_q;
		ahead    = neighbor(row_q, col_q, hd_q);
		tgt_next = '0;

		if (fire) begin
			unique case (mode_q)
				ST_ADVANCE: begin
					if (item.wall_front || at_goal) begin
						cmd    = CMD_STOP;
						n_mode = ST_BRAKE;
					end
					if (item.wheel_count >= steps_cell) begin
						clr = 1'b1;
						we  = 1'b1;
						if (ahead.ok) begin
							n_row = ahead.row;
							n_col = ahead.col;
							moved = 1'b1;
						end else begin
							blk = 1'b1;
						end
					end
				end
				ST_BRAKE: begin
					if (item.is_stopped) begin
						n_mode = ST_HALT;
						if (item.wall_front || at_goal) begin
							if (!item.wall_right) n_thd = thd_q + 2'd1;
							else if (!item.wall_left) n_thd = thd_q + 2'd3;
							else if (item.wall_front) n_thd = thd_q + 2'd1;
						end
					end
				end
				ST_HALT: begin
					if (hd_q == thd_q) begin
						if (!at_goal) begin
							cmd    = CMD_FORWARD;
							n_mode = ST_ADVANCE;
						end
					end else begin
						if (diff == 2'd3) begin
							cmd   = CMD_LEFT;
							n_phd = phd_q + 2'd3;
						end else begin
							cmd   = CMD_RIGHT;
							n_phd = phd_q + 2'd1;
						end
						n_mode = ST_TURN;
					end
				end
				ST_TURN: begin
					if (item.wheel_count >= steps_turn) begin
						clr    = 1'b1;
						n_hd   = phd_q;
						n_mode = ST_BRAKE;
						cmd    = CMD_STOP;
						turned = 1'b1;
					end
				end
				default: n_mode = ST_ADVANCE;
			endcase

			// Port A looked ahead one cell (pending heading in turn mode),
			// port B two cells in advance mode, else one cell.
			priority if (mode_q == ST_ADVANCE) next_vis = moved ? stat.vis_b : stat.vis_a;
			else if (mode_q == ST_TURN) next_vis = turned ? stat.vis_a : stat.vis_b;
			else next_vis = stat.vis_b;

			// goal advance sees the updated pose
			if ((n_hd == n_thd) && (n_row == trow_q) && (n_col == tcol_q)
					&& !item.wall_front) begin
				if (!((!item.wall_right || !item.wall_left) && next_vis)) begin
					tgt_next = neighbor(trow_q, tcol_q, n_thd);
					if (tgt_next.ok) begin
						n_trow = tgt_next.row;
						n_tcol = tgt_next.col;
					end else begin
						blk = 1'b1;
					end
				end
			end
		end
	end

	// Lookups for the tick after this edge, from the next state
	always_comb begin
		rd_hd = (n_mode == ST_TURN) ? n_phd : n_hd;
		rd_a  = neighbor(n_row, n_col, rd_hd);
		rd_b  = neighbor(n_row, n_col, n_hd);
		if (n_mode == ST_ADVANCE) begin
			// port A holds the one-ahead cell here
			rd_b    = neighbor(rd_b.row, rd_b.col, n_hd);
			rd_b.ok = rd_b.ok && rd_a.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_ADVANCE;
			row_q  <= 4'd0;
			col_q  <= 4'd0;
			hd_q   <= HD_NORTH;
			trow_q <= 4'd1;
			tcol_q <= 4'd0;
			thd_q  <= HD_NORTH;
			phd_q  <= HD_NORTH;
		end else begin
			mode_q <= n_mode;
			row_q  <= n_row;
			col_q  <= n_col;
			hd_q   <= n_hd;
			trow_q <= n_trow;
			tcol_q <= n_tcol;
			thd_q  <= n_thd;
			phd_q  <= n_phd;
		end
	end

	assign req.we     = we;
	assign req.wr_row = row_q;
	assign req.wr_col = col_q;
	assign req.rd_a   = rd_a;
	assign req.rd_b   = rd_b;

	assign result.motor_cmd         = cmd;
	assign result.clear_wheel_count = clr;
	assign result.mode              = mode_code(n_mode);
	assign result.pos_row           = n_row;
	assign result.pos_col           = n_col;
	assign result.heading           = n_hd;
	assign result.goal_row          = n_trow;
	assign result.goal_col          = n_tcol;
	assign result.goal_heading      = n_thd;
	assign result.move_blocked      = blk;

endmodule

FILE: rtl/maze_robot_navigation_fsm.sv
// Maze robot navigation controller, top level: request and result channels,
// configuration registers, output register. Depends on mrn_pkg, mrn_ctrl, mrn_visit.
//
// One control tick per request, one result per request. A request is taken
// every clock cycle while the result register is empty or being drained, so
// sustained rate is one tick per cycle; the result is registered and is
// shown in the cycle after acceptance. Rate is set by the visited map: both
// map lookups a tick may need (one and two cells ahead, or one cell along
// the pending turn) are read from the map RAMs at the edge that updates the
// pose, so the registered read data is ready when the next request arrives,
// with same-edge writes forwarded. After reset the map is cleared by a sweep
// over all GRID_ROWS*GRID_COLS cells (256 at the default size) during which
// in_ready stays low; configuration writes are taken at any time. Moves
// leaving the grid are suppressed and reported on move_blocked.
module maze_robot_navigation_fsm
	import mrn_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic       fire;
	logic [7:0] steps_cell_q, steps_turn_q;
	logic       out_valid_q;
	out_t       out_data_q;
	out_t       result;
	map_req_t   req;
	map_stat_t  stat;

	// accept while the map is ready and the result slot frees up this cycle
	assign in_ready = !stat.busy && (!out_valid_q || out_ready);
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_cell_q <= 8'd4;
			steps_turn_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEPS_CELL: steps_cell_q <= cfg_wdata;
				REG_STEPS_TURN: steps_turn_q <= cfg_wdata;
			endcase
		end
	end

	mrn_ctrl #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (in_data),
		.steps_cell (steps_cell_q),
		.steps_turn (steps_turn_q),
		.stat       (stat),
		.result     (result),
		.req        (req)
	);

	mrn_visit #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_visit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	// result register: new result loads on accept, otherwise held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: test/mrn_nav_checker.sv
// Scoreboard for the maze robot navigation controller: tracks pose, goal and
// visited cells per tick, predicts each result and compares it. Depends on mrn_pkg.
module mrn_nav_checker
	import mrn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_t        in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_t       out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         bad_results,
	output int         ticks_pending
);

	logic [7:0] cell_steps, turn_steps;
	logic [1:0] mode_q, hd_q, goal_hd_q, pend_hd_q;
	logic [3:0] row_q, col_q, goal_row_q, goal_col_q;
	logic       seen [256];
	out_t       tick_q [$];
	int         n_bad = 0;
	int         n_pending = 0;

	assign bad_results   = n_bad;
	assign ticks_pending = n_pending;

	function automatic logic on_goal();
		return row_q == goal_row_q && col_q == goal_col_q;
	endfunction

	// Neighbor cell along heading h; 0 when it falls off the grid.
	function automatic logic next_cell(input logic [3:0] r, c, input logic [1:0] h,
			output logic [3:0] nr, nc);
		nr = r;
		nc = c;
		case (h)
			HD_NORTH: begin
				if (r >= GRID_ROWS_DEF - 1) return 1'b0;
				nr = r + 4'd1;
			end
			HD_EAST: begin
				if (c >= GRID_COLS_DEF - 1) return 1'b0;
				nc = c + 4'd1;
			end
			HD_SOUTH: begin
				if (r == 4'd0) return 1'b0;
				nr = r - 4'd1;
			end
			default: begin
				if (c == 4'd0) return 1'b0;
				nc = c - 4'd1;
			end
		endcase
		return 1'b1;
	endfunction

	// One control tick: mode logic first, then the goal-advance check.
	function automatic out_t run_tick(input in_t r);
		out_t       res;
		logic [2:0] cmd;
		logic       clr, blk, ahead_seen;
		logic [3:0] nr, nc;
		cmd = CMD_NONE;
		clr = 1'b0;
		blk = 1'b0;
		case (mode_q)
			MODE_ADVANCE: begin
				if (r.wall_front || on_goal()) begin
					cmd = CMD_STOP;
					mode_q = MODE_BRAKE;
				end
				if (r.wheel_count >= cell_steps) begin
					clr = 1'b1;
					seen[{row_q, col_q}] = 1'b1;
					if (next_cell(row_q, col_q, hd_q, nr, nc)) begin
						row_q = nr;
						col_q = nc;
					end else begin
						blk = 1'b1;
					end
				end
			end
			MODE_BRAKE: begin
				if (r.is_stopped) begin
					mode_q = MODE_HALT;
					if (r.wall_front || on_goal()) begin
						if (!r.wall_right)
							goal_hd_q = goal_hd_q + 2'd1;
						else if (!r.wall_left)
							goal_hd_q = goal_hd_q - 2'd1;
						else if (r.wall_front)
							goal_hd_q = goal_hd_q + 2'd1;
					end
				end
			end
			MODE_HALT: begin
				if (hd_q == goal_hd_q) begin
					if (!on_goal()) begin
						cmd = CMD_FORWARD;
						mode_q = MODE_ADVANCE;
					end
				end else begin
					// shortest way round: a quarter to the left only when goal is one step ccw
					if (2'(goal_hd_q - hd_q) == 2'd3) begin
						cmd = CMD_LEFT;
						pend_hd_q = pend_hd_q - 2'd1;
					end else begin
						cmd = CMD_RIGHT;
						pend_hd_q = pend_hd_q + 2'd1;
					end
					mode_q = MODE_TURN;
				end
			end
			default: begin
				if (r.wheel_count >= turn_steps) begin
					clr = 1'b1;
					hd_q = pend_hd_q;
					mode_q = MODE_BRAKE;
					cmd = CMD_STOP;
				end
			end
		endcase

		if (hd_q == goal_hd_q && on_goal() && !r.wall_front) begin
			ahead_seen = 1'b0;
			if (next_cell(row_q, col_q, hd_q, nr, nc))
				ahead_seen = seen[{nr, nc}];
			if (!((!r.wall_right || !r.wall_left) && ahead_seen)) begin
				if (next_cell(goal_row_q, goal_col_q, goal_hd_q, nr, nc)) begin
					goal_row_q = nr;
					goal_col_q = nc;
				end else begin
					blk = 1'b1;
				end
			end
		end

		res.motor_cmd         = cmd;
		res.clear_wheel_count = clr;
		res.mode              = mode_q;
		res.pos_row           = row_q;
		res.pos_col           = col_q;
		res.heading           = hd_q;
		res.goal_row          = goal_row_q;
		res.goal_col          = goal_col_q;
		res.goal_heading      = goal_hd_q;
		res.move_blocked      = blk;
		return res;
	endfunction

	function automatic logic field_bad(input string name, input int unsigned want, got);
		if (want != got && n_bad < 10)
			$display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
		return want != got;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		logic bad;
		if (!arst_n) begin
			cell_steps = 8'd4;
			turn_steps = 8'd2;
			mode_q     = MODE_ADVANCE;
			row_q      = 4'd0;
			col_q      = 4'd0;
			hd_q       = HD_NORTH;
			goal_row_q = 4'd1;
			goal_col_q = 4'd0;
			goal_hd_q  = HD_NORTH;
			pend_hd_q  = HD_NORTH;
			for (int i = 0; i < 256; i++) seen[i] = 1'b0;
			tick_q.delete();
			n_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_STEPS_CELL)
					cell_steps = cfg_wdata;
				else
					turn_steps = cfg_wdata;
			end
			if (in_valid && in_ready)
				tick_q.push_back(run_tick(in_data));
			if (out_valid && out_ready) begin
				if (tick_q.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: unexpected result %p", $realtime, out_data);
					n_bad++;
				end else begin
					want = tick_q.pop_front();
					bad = field_bad("motor_cmd", want.motor_cmd, out_data.motor_cmd)
						| field_bad("clear_wheel_count", want.clear_wheel_count,
							out_data.clear_wheel_count)
						| field_bad("mode", want.mode, out_data.mode)
						| field_bad("pos_row", want.pos_row, out_data.pos_row)
						| field_bad("pos_col", want.pos_col, out_data.pos_col)
						| field_bad("heading", want.heading, out_data.heading)
						| field_bad("goal_row", want.goal_row, out_data.goal_row)
						| field_bad("goal_col", want.goal_col, out_data.goal_col)
						| field_bad("goal_heading", want.goal_heading, out_data.goal_heading)
						| field_bad("move_blocked", want.move_blocked, out_data.move_blocked);
					if (bad) n_bad++;
				end
			end
			n_pending <= tick_q.size();
		end
	end

endmodule

FILE: test/tb_maze_robot_navigation_fsm.sv
// Testbench top for maze_robot_navigation_fsm: drives control-tick requests,
// step registers and result back-pressure. Depends on mrn_pkg, mrn_nav_checker.
module tb_maze_robot_navigation_fsm;
	import mrn_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_t        in_data;
	logic       out_valid;
	logic       out_ready;
	out_t       out_data;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	int bad_results;
	int ticks_pending;

	// Per-phase idle odds (percent of cycles) and the long receiver hold-off.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left   = 0;

	// Step register settings per random phase: extremes, zero (instant
	// completion) and a few ordinary values.
	logic [7:0] cell_tab [6] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd255};
	logic [7:0] turn_tab [6] = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd3, 8'd1};

	localparam int PHASE_REQS = 265;

	maze_robot_navigation_fsm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mrn_nav_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.bad_results   (bad_results),
		.ticks_pending (ticks_pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic in_t mk_req(input logic f, r, l, s, input logic [7:0] cnt);
		in_t q;
		q.wall_front  = f;
		q.wall_right  = r;
		q.wall_left   = l;
		q.is_stopped  = s;
		q.wheel_count = cnt;
		return q;
	endfunction

	// Random tick. Counts cluster near small step values and at saturation
	// so moves and turns complete often, even with the 255 settings.
	function automatic in_t rand_req();
		int         pick;
		logic [7:0] cnt;
		pick = $urandom_range(99);
		if (pick < 45)
			cnt = 8'($urandom_range(4));
		else if (pick < 65)
			cnt = 8'd255;
		else if (pick < 75)
			cnt = 8'($urandom_range(255, 250));
		else
			cnt = 8'($urandom_range(255));
		return mk_req($urandom_range(99) < 30, $urandom_range(99) < 40,
			$urandom_range(99) < 40, $urandom_range(99) < 60, cnt);
	endfunction

	// Offer one request; hold valid and payload until the block takes it.
	task automatic send_req(input in_t req);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Step registers go in back to back; only called with the block idle.
	task automatic write_steps(input logic [7:0] per_cell, turn);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STEPS_CELL;
		cfg_wdata <= per_cell;
		@(posedge clk);
		cfg_index <= REG_STEPS_TURN;
		cfg_wdata <= turn;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid and wait for every outstanding result, plus a short tail.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ticks_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stalls, or a counted hold-off when one is requested.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_STEPS_CELL;
		cfg_wdata <= 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk with short steps: move onto the goal, brake on a front
		// wall, turn right and left, goal stepping ahead, walls on all sides,
		// counts at 0 and 255. Requests wait out the map clearing sweep.
		write_steps(8'd2, 8'd1);
		send_req(mk_req(0, 0, 0, 0, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd255));
		send_req(mk_req(0, 1, 1, 0, 8'd1));
		send_req(mk_req(1, 1, 1, 0, 8'd2));
		send_req(mk_req(1, 1, 1, 0, 8'd0));
		send_req(mk_req(1, 1, 1, 1, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd1));
		send_req(mk_req(0, 0, 0, 1, 8'd0));
		send_req(mk_req(0, 0, 1, 0, 8'd0));
		send_req(mk_req(1, 0, 0, 0, 8'd255));
		send_req(mk_req(0, 1, 0, 1, 8'd3));
		send_req(mk_req(0, 1, 1, 1, 8'd0));
		send_req(mk_req(0, 1, 1, 1, 8'd255));
		send_req(mk_req(0, 0, 0, 1, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd0));
		send_req(mk_req(0, 0, 0, 0, 8'd255));
		send_req(mk_req(1, 1, 1, 1, 8'd255));
		send_req(mk_req(1, 1, 1, 1, 8'd128));
		send_req(mk_req(0, 1, 0, 1, 8'd127));
		send_req(mk_req(1, 0, 1, 0, 8'd255));

		// Random phases: receiver-heavy idling, then sender-heavy, then none.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_steps(cell_tab[ph], turn_tab[ph]);
			tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 45 : 0;
			rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 26 : 0;
			for (int i = 0; i < PHASE_REQS; i++) begin
				// Long result stall while requests keep coming: fills the
				// output register and forces in_ready low.
				if (ph == 4 && i == 100) hold_left = 80;
				send_req(rand_req());
			end
		end
		drain();

		if (bad_results == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run including the clearing sweep.
	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
